// ===== rtl/sqi_pkg.sv =====
// ============================================================================
// sqi_pkg - shared types and constants of the sorted insert queue
// Field widths, operation and status codes, and the token control group.
// ============================================================================
package sqi_pkg;

    // Request and result field widths
    localparam int OP_W     = 1;
    localparam int KEY_IN_W = 32;
    localparam int STATUS_W = 2;
    localparam int KEY_OUT_W = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int RES_W    = 72;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
    localparam logic [OP_W-1:0] OP_POP  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd2;

    // Register index of the ordering mode
    localparam logic REG_SORT_DESC = 1'b0;

    // Control part of the insertion token that walks down the cell row
    typedef struct packed {
        logic valid;  // token present at this cell
        logic shift;  // insert point passed: every later cell moves down
    } t_tok_ctl;

endpackage

// ===== rtl/sqi_cell.sv =====
// ============================================================================
// sqi_cell - one storage cell of the sorted queue row
// Holds one key, compares it with a passing insertion token and either keeps
// it or swaps it down the row; takes its neighbor's key on a pop.
// ============================================================================
module sqi_cell
    import sqi_pkg::*;
#(
    parameter int KEY_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_desc,
    input  logic                 i_cell_valid,
    input  logic                 i_pop,
    input  logic [KEY_WIDTH-1:0] i_next_key,
    input  t_tok_ctl             i_tok_ctl,
    input  logic [KEY_WIDTH-1:0] i_tok_key,
    output t_tok_ctl             o_tok_ctl,
    output logic [KEY_WIDTH-1:0] o_tok_key,
    output logic [KEY_WIDTH-1:0] o_key
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    t_tok_ctl             r_tok_ctl;
    t_tok_ctl             n_tok_ctl;
    logic [KEY_WIDTH-1:0] r_tok_key;
    logic [KEY_WIDTH-1:0] n_tok_key;
    logic                 w_le;

    // stored key orders before or equal to the travelling key
    assign w_le = i_desc ? (r_key >= i_tok_key) : (r_key <= i_tok_key);

    always_comb begin
        n_key     = r_key;
        n_tok_ctl = '0;
        n_tok_key = r_tok_key;
        if (i_tok_ctl.valid) begin
            if (!i_cell_valid) begin
                // end of stored keys: drop the token here
                n_key = i_tok_key;
            end else if (i_tok_ctl.shift || !w_le) begin
                n_key           = i_tok_key;
                n_tok_ctl.valid = 1'b1;
                n_tok_ctl.shift = 1'b1;
                n_tok_key       = r_key;
            end else begin
                n_tok_ctl.valid = 1'b1;
                n_tok_key       = i_tok_key;
            end
        end else if (i_pop) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_ctl <= '0;
        end else begin
            r_tok_ctl <= n_tok_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_tok_key <= n_tok_key;
    end

    assign o_tok_ctl = r_tok_ctl;
    assign o_tok_key = r_tok_key;
    assign o_key     = r_key;

endmodule

// ===== rtl/sorted_insert_queue.sv =====
// ============================================================================
// sorted_insert_queue - bounded queue of unsigned keys kept in sorted order
// Push inserts a key behind every stored key that orders before or equal to
// it; pop removes the front key. One result per request.
// ============================================================================
//
//  channel   | direction | accepted when                     | content
//  ----------+-----------+-----------------------------------+---------------------
//  s_axis    | in        | tvalid & tready                   | key, operation
//  m_axis    | out       | tvalid & tready                   | status, keys, count
//  apb       | in        | psel & penable & pwrite & pready  | sort_descending
//
//  A pop goes from acceptance through the hold state to the result register;
//  a push first walks the insertion token down the cell row one cell per
//  cycle until it lands in the first empty cell. A refused request goes to hold.
//  Reset is synchronous and clears the count, the mode and all tokens; the
//  key cells are not cleared. While a result waits on m_axis the next request
//  is held off only once its own result is ready to be handed over.
//
module sorted_insert_queue
    import sqi_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [KEY_IN_W-1:0]  i_s_axis_tdata,   // [31:0] key
    input  logic [OP_W-1:0]      i_s_axis_tuser,   // [0] operation
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [RES_W-1:0]     o_m_axis_tdata,   // [1:0] status, [33:2] popped_key,
                                                   // [65:34] front_key,
                                                   // [70:66] entry_count, [71] queue_empty
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PUSH = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_step, n_step;
    logic                 r_desc;
    logic [KEY_WIDTH-1:0] r_key, n_key;

    // pending result, held until the output register is free
    logic [STATUS_W-1:0]  r_pend_status, n_pend_status;
    logic [KEY_OUT_W-1:0] r_pend_popped, n_pend_popped;
    logic [KEY_OUT_W-1:0] r_pend_front, n_pend_front;
    logic [CW-1:0]        r_pend_count, n_pend_count;

    logic                 r_out_valid, n_out_valid;
    logic [RES_W-1:0]     r_out_data, n_out_data;

    // ------------------------------------------------------------------
    // Cell row wiring
    // ------------------------------------------------------------------
    t_tok_ctl             w_tok_ctl [CAPACITY+1];
    logic [KEY_WIDTH-1:0] w_tok_key [CAPACITY+1];
    logic [KEY_WIDTH-1:0] w_key     [CAPACITY];
    logic                 w_pop;
    logic                 w_accept;
    logic [KEY_WIDTH-1:0] w_in_key;
    logic [KEY_OUT_W-1:0] w_front_now;
    logic [KEY_OUT_W-1:0] w_second_now;
    logic [KEY_OUT_W-1:0] w_new_key_out;
    logic                 w_out_free;
    logic [CW+COUNT_OUT_W-1:0] w_count_ext;

    logic [KEY_WIDTH+KEY_IN_W-1:0]  w_in_ext;
    logic [KEY_WIDTH+KEY_OUT_W-1:0] w_k0_ext;
    logic [KEY_WIDTH+KEY_OUT_W-1:0] w_k1_ext;
    logic [KEY_WIDTH+KEY_OUT_W-1:0] w_kn_ext;

    // reduce the incoming key to KEY_WIDTH bits, widen stored keys to 32
    assign w_in_ext = {{KEY_WIDTH{1'b0}}, i_s_axis_tdata};
    assign w_in_key = w_in_ext[KEY_WIDTH-1:0];
    assign w_k0_ext = {{KEY_OUT_W{1'b0}}, w_key[0]};
    assign w_k1_ext = {{KEY_OUT_W{1'b0}}, w_key[1]};
    assign w_kn_ext = {{KEY_OUT_W{1'b0}}, r_key};
    assign w_front_now   = w_k0_ext[KEY_OUT_W-1:0];
    assign w_second_now  = w_k1_ext[KEY_OUT_W-1:0];
    assign w_new_key_out = w_kn_ext[KEY_OUT_W-1:0];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // pop shifts the whole row toward the front in the accept cycle
    assign w_pop = w_accept && (i_s_axis_tuser == OP_POP) && (r_count != '0);

    // inject the token into the front cell on the first push cycle
    assign w_tok_ctl[0].valid = (r_state == S_PUSH) && (r_step == '0);
    assign w_tok_ctl[0].shift = 1'b0;
    assign w_tok_key[0]       = r_key;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                 w_valid;
            logic [KEY_WIDTH-1:0] w_next;

            assign w_valid = (CW'(gi) < r_count);
            if (gi == CAPACITY - 1) begin : g_last
                assign w_next = w_key[gi];
            end else begin : g_mid
                assign w_next = w_key[gi+1];
            end

            sqi_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_desc       (r_desc),
                .i_cell_valid (w_valid),
                .i_pop        (w_pop),
                .i_next_key   (w_next),
                .i_tok_ctl    (w_tok_ctl[gi]),
                .i_tok_key    (w_tok_key[gi]),
                .o_tok_ctl    (w_tok_ctl[gi+1]),
                .o_tok_key    (w_tok_key[gi+1]),
                .o_key        (w_key[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_count_ext = {{COUNT_OUT_W{1'b0}}, r_pend_count};

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_step        = r_step;
        n_key         = r_key;
        n_pend_status = r_pend_status;
        n_pend_popped = r_pend_popped;
        n_pend_front  = r_pend_front;
        n_pend_count  = r_pend_count;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_data    = r_out_data;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pend_popped = '0;
                    n_pend_count  = r_count;
                    n_pend_front  = (r_count != '0) ? w_front_now : '0;
                    if (i_s_axis_tuser == OP_PUSH) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_pend_status = ST_PUSH_FULL;
                            n_state       = S_HOLD;
                        end else begin
                            // latch the key and start the token walk
                            n_key   = w_in_key;
                            n_step  = '0;
                            n_state = S_PUSH;
                        end
                    end else if (r_count == '0) begin
                        n_pend_status = ST_POP_EMPTY;
                        n_state       = S_HOLD;
                    end else begin
                        n_pend_status = ST_OK;
                        n_pend_popped = w_front_now;
                        n_pend_front  = (r_count > CW'(1)) ? w_second_now : '0;
                        n_count       = r_count - CW'(1);
                        n_pend_count  = r_count - CW'(1);
                        n_state       = S_HOLD;
                    end
                end
            end
            S_PUSH: begin
                // token sits at cell r_step; it lands when it reaches the tail
                if (r_step == r_count) begin
                    n_pend_status = ST_OK;
                    n_pend_popped = '0;
                    n_pend_front  = (r_count == '0) ? w_new_key_out : w_front_now;
                    n_count       = r_count + CW'(1);
                    n_pend_count  = r_count + CW'(1);
                    n_state       = S_HOLD;
                end else begin
                    n_step = r_step + CW'(1);
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {(r_pend_count == '0), w_count_ext[COUNT_OUT_W-1:0],
                                   r_pend_front, r_pend_popped, r_pend_status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_pend_status <= n_pend_status;
        r_pend_popped <= n_pend_popped;
        r_pend_front  <= n_pend_front;
        r_pend_count  <= n_pend_count;
        r_out_data    <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Configuration port: one mode register, writes elsewhere are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SORT_DESC)) begin
            r_desc <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SORT_DESC) ? {31'd0, r_desc} : 32'd0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_tail_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_tok_ctl[CAPACITY].valid)
        else $error("insertion token ran past the last cell");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("stored count above capacity");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> (r_step <= r_count))
        else $error("token walk went past the tail");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("request accepted without starting work");

endmodule
